>>> rtl/ftn_ap_pkg.sv
// ---------------------------------------------------------------------------
// ftn_ap_pkg
// Types and constants shared by the FTN address parser modules.
// ---------------------------------------------------------------------------
package ftn_ap_pkg;

  localparam int NUM_W   = 16;
  localparam int CHAR_W  = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [NUM_W-1:0] NUM_MAX = 16'hFFFF;

  localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_ZONE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_NET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_NODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_KNOWN = 2'd3;

  // Bit positions in the part flags.
  localparam int F_ZONE  = 0;
  localparam int F_NET   = 1;
  localparam int F_NODE  = 2;
  localparam int F_POINT = 3;

  typedef enum logic [2:0] {
    PH_START,
    PH_FIRST,
    PH_NET,
    PH_NODE,
    PH_POINT,
    PH_PONLY
  } phase_t;

  typedef struct packed {
    logic             ok;
    logic [3:0]       flags;
    logic [NUM_W-1:0] zone;
    logic [NUM_W-1:0] net;
    logic [NUM_W-1:0] node;
    logic [NUM_W-1:0] point;
  } parse_res_t;

  typedef struct packed {
    logic             known;
    logic [NUM_W-1:0] zone;
    logic [NUM_W-1:0] net;
    logic [NUM_W-1:0] node;
  } area_cfg_t;

endpackage

>>> rtl/ftn_ap_core.sv
// ---------------------------------------------------------------------------
// ftn_ap_core
// Running parse state and the per-character step; gives the parse result
// for the character being taken when it is the last one of the token.
// ---------------------------------------------------------------------------
module ftn_ap_core
  import ftn_ap_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last,
  output parse_res_t        res
);

  phase_t           phase, phase_next, t_phase;
  logic [NUM_W-1:0] acc, acc_next, t_acc;
  logic [NUM_W-1:0] first_number, first_number_next, t_first;
  logic [NUM_W-1:0] net_val, net_val_next, t_net;
  logic [NUM_W-1:0] node_val, node_val_next, t_node;
  logic [3:0]       flags, flags_next, t_flags;
  logic             digit_seen, digit_seen_next, t_digit;
  logic             pending_space, pending_space_next, t_pending;
  logic             after_at, after_at_next, t_after;
  logic             failed, failed_next, t_failed;

  logic             is_digit, is_ws;
  logic [3:0]       dval;
  logic [19:0]      acc_mul;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_ws    = (char_code == CH_SPACE) ||
                    ((char_code >= CH_TAB) && (char_code <= CH_CR));
  assign dval     = 4'(char_code - CH_ZERO);
  assign acc_mul  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'h0000, dval};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      acc           <= '0;
      first_number  <= '0;
      net_val       <= '0;
      node_val      <= '0;
      flags         <= '0;
      digit_seen    <= 1'b0;
      pending_space <= 1'b0;
      after_at      <= 1'b0;
      failed        <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      acc           <= acc_next;
      first_number  <= first_number_next;
      net_val       <= net_val_next;
      node_val      <= node_val_next;
      flags         <= flags_next;
      digit_seen    <= digit_seen_next;
      pending_space <= pending_space_next;
      after_at      <= after_at_next;
      failed        <= failed_next;
    end
  end

  always_comb begin
    t_phase   = phase;
    t_acc     = acc;
    t_first   = first_number;
    t_net     = net_val;
    t_node    = node_val;
    t_flags   = flags;
    t_digit   = digit_seen;
    t_pending = pending_space;
    t_after   = after_at;
    t_failed  = failed;

    if (!failed && !after_at) begin
      if (is_ws) begin
        if (phase != PH_START) t_pending = 1'b1;
      end else if (pending_space) begin
        t_failed = 1'b1;
      end else if (char_code == CH_AT) begin
        t_after = 1'b1;
      end else if (is_digit && phase != PH_START) begin
        t_acc   = acc_mul[NUM_W-1:0];
        t_digit = 1'b1;
        if (acc_mul > {4'h0, NUM_MAX}) t_failed = 1'b1;
      end else begin
        unique case (phase)
          PH_START: begin
            if (char_code == CH_DOT) begin
              t_phase = PH_PONLY;
              t_acc   = '0;
              t_digit = 1'b0;
            end else if (char_code == CH_SLASH) begin
              t_phase = PH_NODE;
              t_acc   = '0;
              t_digit = 1'b0;
            end else if (is_digit) begin
              t_phase = PH_FIRST;
              t_acc   = {12'h000, dval};
              t_digit = 1'b1;
            end else begin
              t_failed = 1'b1;
            end
          end
          PH_FIRST: begin
            if (char_code == CH_COLON) begin
              t_first = acc;
              t_phase = PH_NET;
              t_acc   = '0;
              t_digit = 1'b0;
            end else if (char_code == CH_SLASH) begin
              t_net          = acc;
              t_flags[F_NET] = 1'b1;
              t_phase        = PH_NODE;
              t_acc          = '0;
              t_digit        = 1'b0;
            end else begin
              t_failed = 1'b1;
            end
          end
          PH_NET: begin
            if (char_code == CH_SLASH && digit_seen) begin
              t_net           = acc;
              t_flags[F_ZONE] = 1'b1;
              t_flags[F_NET]  = 1'b1;
              t_phase         = PH_NODE;
              t_acc           = '0;
              t_digit         = 1'b0;
            end else begin
              t_failed = 1'b1;
            end
          end
          PH_NODE: begin
            if (char_code == CH_DOT && digit_seen) begin
              t_node          = acc;
              t_flags[F_NODE] = 1'b1;
              t_phase         = PH_POINT;
              t_acc           = '0;
              t_digit         = 1'b0;
            end else begin
              t_failed = 1'b1;
            end
          end
          default: t_failed = 1'b1;
        endcase
      end
    end

    // Result as seen after this character; the last number closes either
    // the node or the point.
    res.ok    = !t_failed && t_digit &&
                (t_phase == PH_NODE || t_phase == PH_POINT || t_phase == PH_PONLY);
    res.flags = t_flags;
    res.zone  = t_first;
    res.net   = t_net;
    res.node  = t_node;
    res.point = '0;
    if (res.ok) begin
      if (t_phase == PH_NODE) begin
        res.node            = t_acc;
        res.flags[F_NODE]   = 1'b1;
      end else begin
        res.point           = t_acc;
        res.flags[F_POINT]  = 1'b1;
      end
    end

    if (last) begin
      phase_next         = PH_START;
      acc_next           = '0;
      first_number_next  = '0;
      net_val_next       = '0;
      node_val_next      = '0;
      flags_next         = '0;
      digit_seen_next    = 1'b0;
      pending_space_next = 1'b0;
      after_at_next      = 1'b0;
      failed_next        = 1'b0;
    end else begin
      phase_next         = t_phase;
      acc_next           = t_acc;
      first_number_next  = t_first;
      net_val_next       = t_net;
      node_val_next      = t_node;
      flags_next         = t_flags;
      digit_seen_next    = t_digit;
      pending_space_next = t_pending;
      after_at_next      = t_after;
      failed_next        = t_failed;
    end
  end

endmodule

>>> rtl/ftn_ap_out.sv
// ---------------------------------------------------------------------------
// ftn_ap_out
// Completes the parsed address from the area address and holds the result
// transaction in the output register until it is taken.
// ---------------------------------------------------------------------------
module ftn_ap_out
  import ftn_ap_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  parse_res_t             res,
  input  area_cfg_t              area,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic             comp;
  logic             r_ok, r_comp;
  logic [3:0]       r_flags;
  logic [NUM_W-1:0] r_zone, r_net, r_node, r_point;
  logic             out_valid;

  assign comp = res.ok && (res.flags[F_ZONE] || area.known);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r_ok    <= res.ok;
      r_comp  <= comp;
      r_flags <= res.ok ? res.flags : 4'h0;
      r_zone  <= !comp ? '0 : (res.flags[F_ZONE]  ? res.zone  : area.zone);
      r_net   <= !comp ? '0 : (res.flags[F_NET]   ? res.net   : area.net);
      r_node  <= !comp ? '0 : (res.flags[F_NODE]  ? res.node  : area.node);
      r_point <= !comp ? '0 : (res.flags[F_POINT] ? res.point : '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, r_point, r_node, r_net, r_zone, r_comp,
                          r_flags[F_POINT], r_flags[F_NODE], r_flags[F_NET],
                          r_flags[F_ZONE], r_ok};

  // A result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || m_axis_tready))
    else $error("result register overwritten before transaction");

  a_comp_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!r_comp || r_ok))
    else $error("complete_ok without parsed_ok");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !r_ok) |-> (r_flags == 4'h0 && r_zone == '0 && r_point == '0))
    else $error("failed parse carries nonzero fields");

  a_ok_has_tail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && r_ok) |-> (r_flags[F_NODE] || r_flags[F_POINT]))
    else $error("parsed address without node or point");

endmodule

>>> rtl/ftn_address_parser_top.sv
// ---------------------------------------------------------------------------
// ftn_address_parser_top
// FidoNet address parser: takes a token one character per transaction and
// gives the parsed and completed address on the token's last character.
// ---------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] char_code, tlast = last
//  m_axis    out        tdata[71:0] result, one per token
//  cfg       in         cfg_index selects area_zone/net/node/known
//
//  One character per cycle, back to back, but for a last character that waits
//  as below; a character is taken into the input register, its result into the result register.
//  A character without tlast never waits; a last character waits in the
//  input register only while an earlier result is still held on m_axis.
//  Reset clears the parse state and the area registers to zero.
//  cfg_ready is always high.
module ftn_address_parser_top
  import ftn_ap_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] char_code
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] parsed_ok, [1] has_zone, [2] has_net, [3] has_node, [4] has_point,
  // [5] complete_ok, [21:6] zone_out, [37:22] net_out, [53:38] node_out,
  // [69:54] point_out, [71:70] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;
  logic              advance;
  area_cfg_t         area;
  parse_res_t        res;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata[CHAR_W-1:0];
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_AREA_ZONE:  area.zone  <= cfg_data;
        CFG_AREA_NET:   area.net   <= cfg_data;
        CFG_AREA_NODE:  area.node  <= cfg_data;
        CFG_AREA_KNOWN: area.known <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ftn_ap_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_code (in_char),
    .last      (in_last),
    .res       (res)
  );

  ftn_ap_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && in_last),
    .res           (res),
    .area          (area),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> tb/ftn_address_parser_top_tb.sv
// ---------------------------------------------------------------------------
// ftn_address_parser_top_tb
// Self-checking bench for the FidoNet address parser. Tokens are streamed
// one character per transaction. A tracker follows the parse of every
// accepted character and queues the address expected on each last
// character; every result transaction is checked against the oldest one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftn_address_parser_top_tb
  import ftn_ap_pkg::*;
();

  // Result layout on m_axis_tdata, highest field first.
  typedef struct packed {
    logic [1:0]       pad;
    logic [NUM_W-1:0] point;
    logic [NUM_W-1:0] node;
    logic [NUM_W-1:0] net;
    logic [NUM_W-1:0] zone;
    logic             complete_ok;
    logic             has_point;
    logic             has_node;
    logic             has_net;
    logic             has_zone;
    logic             parsed_ok;
  } addr_fields_t;

  class address_tracker;
    area_cfg_t        area;
    phase_t           ph;
    int unsigned      acc;
    bit               digit_seen;
    bit               pend_blank;
    bit               after_at;
    bit               failed;
    logic [NUM_W-1:0] first_num;
    logic [NUM_W-1:0] parts [4];
    logic [3:0]       flags;
    addr_fields_t     pending_addrs [$];
    int               errors;

    function new();
      area   = '0;
      errors = 0;
      reset_token();
    endfunction

    function void reset_token();
      ph         = PH_START;
      acc        = 0;
      digit_seen = 0;
      pend_blank = 0;
      after_at   = 0;
      failed     = 0;
      first_num  = '0;
      flags      = '0;
      for (int i = 0; i < 4; i++) parts[i] = '0;
    endfunction

    function void write_area(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_AREA_ZONE:  area.zone  = val;
        CFG_AREA_NET:   area.net   = val;
        CFG_AREA_NODE:  area.node  = val;
        CFG_AREA_KNOWN: area.known = val[0];
        default: ;
      endcase
    endfunction

    function bit is_blank(logic [CHAR_W-1:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void parse_char(logic [CHAR_W-1:0] c);
      bit          digit;
      int unsigned dv;
      digit = (c >= CH_ZERO && c <= CH_NINE);
      dv    = 32'(c) - 32'(CH_ZERO);
      if (is_blank(c)) begin
        if (ph != PH_START) pend_blank = 1;
        return;
      end
      // Any non-blank character that follows whitespace inside the token breaks it.
      if (pend_blank) begin
        failed = 1;
        return;
      end
      if (c == CH_AT) begin
        after_at = 1;
        return;
      end
      if (digit && ph != PH_START) begin
        acc = acc * 10 + dv;
        digit_seen = 1;
        if (acc > 32'(NUM_MAX)) failed = 1;
        return;
      end
      case (ph)
        PH_START: begin
          if (c == CH_DOT) begin
            ph = PH_PONLY; acc = 0; digit_seen = 0;
          end else if (c == CH_SLASH) begin
            ph = PH_NODE; acc = 0; digit_seen = 0;
          end else if (digit) begin
            ph = PH_FIRST; acc = dv; digit_seen = 1;
          end else failed = 1;
        end
        PH_FIRST: begin
          if (c == CH_COLON) begin
            first_num = NUM_W'(acc);
            ph = PH_NET; acc = 0; digit_seen = 0;
          end else if (c == CH_SLASH) begin
            parts[1] = NUM_W'(acc);
            flags[F_NET] = 1;
            ph = PH_NODE; acc = 0; digit_seen = 0;
          end else failed = 1;
        end
        PH_NET: begin
          if (c == CH_SLASH && digit_seen) begin
            parts[0] = first_num;
            parts[1] = NUM_W'(acc);
            flags[F_ZONE] = 1;
            flags[F_NET]  = 1;
            ph = PH_NODE; acc = 0; digit_seen = 0;
          end else failed = 1;
        end
        PH_NODE: begin
          if (c == CH_DOT && digit_seen) begin
            parts[2] = NUM_W'(acc);
            flags[F_NODE] = 1;
            ph = PH_POINT; acc = 0; digit_seen = 0;
          end else failed = 1;
        end
        default: failed = 1;
      endcase
    endfunction

    function void accept_char(logic [CHAR_W-1:0] c, logic last);
      addr_fields_t r;
      bit ok;
      if (!failed && !after_at) parse_char(c);
      if (!last) return;
      ok = !failed && digit_seen && (ph == PH_NODE || ph == PH_POINT || ph == PH_PONLY);
      r = '0;
      if (ok) begin
        if (ph == PH_NODE) begin
          parts[2] = NUM_W'(acc);
          flags[F_NODE] = 1;
        end else begin
          parts[3] = NUM_W'(acc);
          flags[F_POINT] = 1;
        end
        r.parsed_ok = 1;
        r.has_zone  = flags[F_ZONE];
        r.has_net   = flags[F_NET];
        r.has_node  = flags[F_NODE];
        r.has_point = flags[F_POINT];
        if (flags[F_ZONE] || area.known) begin
          r.complete_ok = 1;
          r.zone  = flags[F_ZONE]  ? parts[0] : area.zone;
          r.net   = flags[F_NET]   ? parts[1] : area.net;
          r.node  = flags[F_NODE]  ? parts[2] : area.node;
          r.point = flags[F_POINT] ? parts[3] : '0;
        end
      end
      pending_addrs.insert(pending_addrs.size(), r);
      reset_token();
    endfunction

    function string show(addr_fields_t a);
      return $sformatf("ok=%b z%b n%b d%b p%b comp=%b %0d:%0d/%0d.%0d pad=%b",
                       a.parsed_ok, a.has_zone, a.has_net, a.has_node, a.has_point,
                       a.complete_ok, a.zone, a.net, a.node, a.point, a.pad);
    endfunction

    function void check_address(logic [OUT_TDATA_W-1:0] tdata);
      addr_fields_t got;
      addr_fields_t want;
      got = tdata;
      if (pending_addrs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result with none expected: %s", $realtime, show(got));
        return;
      end
      want = pending_addrs.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("%0t: address mismatch\n  expected %s\n  actual   %s",
                   $realtime, show(want), show(got));
      end
    endfunction

    function int pending();
      return pending_addrs.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] char_code
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [0] parsed_ok, [1] has_zone, [2] has_net, [3] has_node, [4] has_point,
  // [5] complete_ok, [21:6] zone_out, [37:22] net_out, [53:38] node_out,
  // [69:54] point_out, [71:70] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  address_tracker    tracker = new();
  logic [CHAR_W-1:0] token_q [$];
  bit                calm = 0;
  int                rx_hold_left = 0;

  ftn_address_parser_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left = rx_hold_left - 1;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_address(m_axis_tdata);
  end

  initial begin
    #2_000_000;
    $display("[ftn_address_parser_top] ERROR");
    $finish;
  end

  function automatic void queue_char(input logic [CHAR_W-1:0] c);
    token_q.insert(token_q.size(), c);
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic l);
    if (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= l;
    do @(posedge clk); while (!s_axis_tready);
    tracker.accept_char(c, l);
  endtask

  task automatic send_token();
    for (int i = 0; i < token_q.size(); i++) send_char(token_q[i], i == token_q.size() - 1);
    token_q.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
    send_token();
  endtask

  // Characters without tlast give no result, so allow the pipeline to empty too.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_area(idx, val);
  endtask

  task automatic set_area(input logic [NUM_W-1:0] z, input logic [NUM_W-1:0] n,
                          input logic [NUM_W-1:0] d, input logic k);
    write_reg(CFG_AREA_ZONE, z);
    write_reg(CFG_AREA_NET, n);
    write_reg(CFG_AREA_NODE, d);
    write_reg(CFG_AREA_KNOWN, {{(CFG_DATA_W-1){1'b0}}, k});
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned pick_number();
    case ($urandom_range(19))
      0, 1:    return 0;
      2, 3:    return 32'(NUM_MAX);
      4:       return $urandom_range(999999, 32'(NUM_MAX) + 1);
      5, 6, 7: return $urandom_range(9);
      8, 9:    return $urandom_range(999);
      default: return $urandom_range(32'(NUM_MAX));
    endcase
  endfunction

  function automatic void put_number(input int unsigned v);
    string s;
    if ($urandom_range(7) == 0) repeat ($urandom_range(3, 1)) queue_char(CH_ZERO);
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endfunction

  function automatic logic [CHAR_W-1:0] blank_char();
    case ($urandom_range(5))
      0:       return CH_SPACE;
      default: return CH_TAB + CHAR_W'($urandom_range(4));
    endcase
  endfunction

  // Half any byte at all, half the bytes that matter to the parser.
  function automatic logic [CHAR_W-1:0] rand_char();
    string pick;
    pick = "0123456789:/.@ \t";
    if ($urandom_range(1)) return CHAR_W'($urandom_range(255));
    return pick[$urandom_range(pick.len() - 1)];
  endfunction

  function automatic void build_address();
    int shape;
    shape = $urandom_range(3);
    if ($urandom_range(4) == 0) repeat ($urandom_range(2, 1)) queue_char(blank_char());
    case (shape)
      0: begin
        put_number(pick_number());
        queue_char(CH_COLON);
        put_number(pick_number());
        queue_char(CH_SLASH);
        put_number(pick_number());
      end
      1: begin
        put_number(pick_number());
        queue_char(CH_SLASH);
        put_number(pick_number());
      end
      2: begin
        queue_char(CH_SLASH);
        put_number(pick_number());
      end
      default: ;
    endcase
    if (shape == 3 || $urandom_range(1)) begin
      queue_char(CH_DOT);
      put_number(pick_number());
    end
    if ($urandom_range(4) == 0) repeat ($urandom_range(2, 1)) queue_char(blank_char());
    if ($urandom_range(6) == 0) begin
      queue_char(CH_AT);
      repeat ($urandom_range(5)) queue_char(rand_char());
    end
  endfunction

  function automatic void build_token();
    int kind;
    int pos;
    kind = $urandom_range(99);
    if (kind < 70) begin
      build_address();
    end else if (kind < 88) begin
      build_address();
      pos = $urandom_range(token_q.size() - 1);
      case ($urandom_range(4))
        0: token_q[pos] = rand_char();
        1: if (token_q.size() > 1) token_q.delete(pos);
        2: token_q.insert(pos, blank_char());
        3: token_q = token_q[0:pos];
        default: begin
          token_q.delete();
          put_number(pick_number());
          if ($urandom_range(1)) queue_char(blank_char());
        end
      endcase
    end else begin
      repeat ($urandom_range(6, 1)) queue_char(rand_char());
    end
  endfunction

  initial begin
    int sent;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed tokens, run with the area address still unknown.
    send_text("0:65535/1.2");
    send_text("/65536");
    send_text(".7");
    send_text("5");
    send_text("\t");
    send_text("@");
    send_text("/ 1");
    queue_char(8'hFF);
    send_token();
    wait_drained();

    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      case (phase_no)
        0: set_area(NUM_MAX, NUM_MAX, NUM_MAX, 1'b1);
        1: set_area('0, '0, '0, 1'b1);
        2: set_area(NUM_W'($urandom()), NUM_W'($urandom()), NUM_W'($urandom()), 1'b1);
        3: set_area(NUM_W'($urandom()), NUM_W'($urandom()), NUM_W'($urandom()), 1'b0);
        4: set_area(NUM_MAX, '0, NUM_MAX, 1'b0);
        default: set_area(NUM_W'($urandom()), NUM_W'($urandom()),
                          NUM_W'($urandom()), 1'($urandom_range(1)));
      endcase
      calm = (phase_no == 3);
      // Stall the receiver for a long stretch so the input side backs up.
      if (phase_no == 2) rx_hold_left = 400;
      sent = 0;
      while (sent < 120) begin
        build_token();
        sent += token_q.size();
        send_token();
        if (phase_no == 1 && sent >= 60 && sent < 75) wait_drained();
      end
      wait_drained();
    end
    calm = 0;

    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ftn_address_parser_top] OK");
    end else begin
      $display("[ftn_address_parser_top] ERROR");
    end
    $finish;
  end

endmodule

>>> ftn_address_parser_top.f
rtl/ftn_ap_pkg.sv
rtl/ftn_ap_core.sv
rtl/ftn_ap_out.sv
rtl/ftn_address_parser_top.sv
tb/ftn_address_parser_top_tb.sv
